// ----- hdl/mts_pkg.sv -----
package mts_pkg;

   localparam int VALUE_W       = 32;
   localparam int COUNT_FIELD_W = 5;
   localparam int STATUS_W      = 2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;

   // operation codes on req_action
   localparam logic ACTION_PUSH = 1'b0;
   localparam logic ACTION_POP  = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic                push_en;
      logic                pop_en;
      logic                fetch_en;
      logic                rsp_load;
      logic [STATUS_W-1:0] rsp_status;
   } mts_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
   } mts_stat_type;

endpackage

// ----- hdl/mts_ram.sv -----
module mts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/mts_ctrl.sv -----
module mts_ctrl
   import mts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_action,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  mts_stat_type dp_stat,
   output mts_cmd_type  dp_cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_RESP  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACTION_PUSH) begin
                  dp_cmd.rsp_load = 1'b1;
                  state_in        = ST_RESP;
                  if (dp_stat.full) begin
                     dp_cmd.rsp_status = STATUS_PUSH_FULL;
                  end else begin
                     dp_cmd.push_en    = 1'b1;
                     dp_cmd.rsp_status = STATUS_OK;
                  end
               end else if (dp_stat.empty) begin
                  dp_cmd.rsp_load   = 1'b1;
                  dp_cmd.rsp_status = STATUS_POP_EMPTY;
                  state_in          = ST_RESP;
               end else begin
                  dp_cmd.pop_en = 1'b1;
                  state_in      = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            dp_cmd.fetch_en   = 1'b1;
            dp_cmd.rsp_load   = 1'b1;
            dp_cmd.rsp_status = STATUS_OK;
            state_in          = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/mts_dpath.sv -----
module mts_dpath
   import mts_pkg::*;
#(
   parameter int STACK_DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic signed [VALUE_W-1:0] req_value,
   input  mts_cmd_type               dp_cmd,
   output mts_stat_type              dp_stat,
   output logic signed [VALUE_W-1:0] rsp_min_value,
   output logic                      rsp_min_valid,
   output logic [COUNT_FIELD_W-1:0]  rsp_entry_count,
   output logic [STATUS_W-1:0]       rsp_status
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic signed [VALUE_W-1:0] top_ff;
   logic signed [VALUE_W-1:0] top_in;
   logic signed [VALUE_W-1:0] push_min;
   logic [VALUE_W-1:0]        rd_data;
   logic [ADDR_W-1:0]         rd_addr;

   logic signed [VALUE_W-1:0]  rsp_min_value_ff;
   logic                       rsp_min_valid_ff;
   logic [COUNT_FIELD_W-1:0]   rsp_entry_count_ff;
   logic [STATUS_W-1:0]        rsp_status_ff;

   assign dp_stat.empty = (count_ff == '0);
   assign dp_stat.full  = (count_ff == CNT_W'(STACK_DEPTH));

   // new level minimum: the value itself on an empty stack
   assign push_min = (dp_stat.empty || (req_value < top_ff)) ? req_value : top_ff;

   // after a pop the new top sits two below the old count
   assign rd_addr = ADDR_W'(count_ff - CNT_W'(2));

   mts_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (STACK_DEPTH)
   ) u_min_store (
      .clock   (clock),
      .wr_en   (dp_cmd.push_en),
      .wr_addr (ADDR_W'(count_ff)),
      .wr_data (push_min),
      .rd_en   (dp_cmd.pop_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      if (dp_cmd.push_en) begin
         count_in = count_ff + CNT_W'(1);
         top_in   = push_min;
      end else if (dp_cmd.pop_en) begin
         count_in = count_ff - CNT_W'(1);
      end else if (dp_cmd.fetch_en) begin
         top_in = $signed(rd_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (dp_cmd.rsp_load) begin
         rsp_min_value_ff   <= (count_in == '0) ? '0 : top_in;
         rsp_min_valid_ff   <= (count_in != '0);
         rsp_entry_count_ff <= COUNT_FIELD_W'(count_in);
         rsp_status_ff      <= dp_cmd.rsp_status;
      end
   end

   assign rsp_min_value   = rsp_min_value_ff;
   assign rsp_min_valid   = rsp_min_valid_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// ----- hdl/min_tracking_stack.sv -----
// bounded stack that tracks the running minimum of its entries. each request
// is a push of a signed 32-bit value or a pop, and each one produces exactly
// one response with the minimum held afterward (zero when empty), a valid flag,
// the entry count and a status: ok, pop on empty ignored, or push on full
// rejected. only per-level minimums are stored, one word per level in a
// STACK_DEPTH-entry ram; the current top minimum is cached in a register.
// one request is in flight at a time: a push, a rejected push or an empty pop
// goes from accept straight to the response state, and a pop of a held entry
// first passes a fetch state for the registered ram read of the new top
// minimum. the stack memory needs no clearing after reset.
module min_tracking_stack
   import mts_pkg::*;
#(
   parameter int STACK_DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_action,
   input  logic signed [VALUE_W-1:0] req_value,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [VALUE_W-1:0] rsp_min_value,
   output logic                      rsp_min_valid,
   output logic [COUNT_FIELD_W-1:0]  rsp_entry_count,
   output logic [STATUS_W-1:0]       rsp_status
);

   mts_cmd_type  dp_cmd;
   mts_stat_type dp_stat;

   // sequencing: accept, optional ram fetch, hold response until transfer
   mts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .dp_stat    (dp_stat),
      .dp_cmd     (dp_cmd)
   );

   // count, cached top minimum, minimum store and response registers
   mts_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_value       (req_value),
      .dp_cmd          (dp_cmd),
      .dp_stat         (dp_stat),
      .rsp_min_value   (rsp_min_value),
      .rsp_min_valid   (rsp_min_valid),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status)
   );

   // a request transfer always closes the request side on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request side open right after a transfer");

   // empty and full can never hold together
   assert property (@(posedge clock) disable iff (reset)
      !(dp_stat.empty && dp_stat.full))
      else $error("stack both empty and full");

   // an ignored pop only happens on an empty stack
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_POP_EMPTY)) |-> !rsp_min_valid)
      else $error("empty-pop status with entries held");

   // a rejected push never reports an empty stack
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_PUSH_FULL)) |-> rsp_min_valid)
      else $error("full-push status on an empty stack");

   // an empty stack reports zero as its minimum
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_min_valid) |-> (rsp_min_value == '0))
      else $error("nonzero minimum on an empty stack");

endmodule
